// ===== src/qgdp_pkg.sv =====
// ----------------------------------------------------------------------------
// qgdp_pkg
// Shared types and constants of the int8 x uint4 group dot product block.
// ----------------------------------------------------------------------------
package qgdp_pkg;

  localparam int MAX_GROUP_LOG2  = 8;
  localparam int SCALE_FRAC_BITS = 24;

  localparam int LOG2_W   = 4;                    // config register width
  localparam int COUNT_W  = MAX_GROUP_LOG2 + 1;   // holds the group size itself
  localparam int DOT_W    = 21;
  localparam int ASUM_W   = 17;
  localparam int SCALE_W  = 31;
  localparam int ZERO_W   = 32;
  localparam int ACC_W    = 64;

  localparam int PWS_W    = 2 * SCALE_W;          // as*ws, unsigned
  localparam int PWZ_W    = ACC_W;                // as*wz, signed
  localparam int SP_W     = PWS_W + 1 - SCALE_FRAC_BITS;  // rounded, with sign bit
  localparam int ZP_W     = PWZ_W - SCALE_FRAC_BITS;
  localparam int T1_W     = DOT_W + SP_W;
  localparam int T2_W     = ASUM_W + ZP_W;

  localparam logic [LOG2_W-1:0] GROUP_LOG2_RST = LOG2_W'(5);
  localparam logic [3:0]        NIBBLE_MASK    = 4'hF;

  typedef struct packed {
    logic signed [7:0]         act_even;
    logic signed [7:0]         act_odd;
    logic [7:0]                weight_pair;
    logic [SCALE_W-1:0]        act_scale;
    logic [SCALE_W-1:0]        weight_scale;
    logic signed [ZERO_W-1:0]  weight_zero;
    logic                      last_of_row;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot_value;
    logic                    saturated;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic acc_en;     // take the input item into the group sums
    logic scale_en;   // scale products
    logic round_en;   // round to fixed point
    logic prod_en;    // group sums times rounded scales
    logic term_en;    // add the two products
    logic row_en;     // saturating row add, restart group
    logic emit_en;    // load output register, restart row
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic close_req;  // incoming item closes its group
    logic last;       // captured item ends the row
  } stat_t;

endpackage

// ===== src/qgdp_datapath.sv =====
// ----------------------------------------------------------------------------
// qgdp_datapath
// Group sums, scale rounding, group products and saturating row accumulator.
// ----------------------------------------------------------------------------
module qgdp_datapath import qgdp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LOG2_W-1:0] cfg_data,
  input  in_item_t          in_item,
  input  cmd_t              cmd,
  output stat_t             stat,
  output out_item_t         out_item
);

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (SCALE_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [LOG2_W-1:0]         lg_r;
  logic [LOG2_W-1:0]         lg_eff;
  logic [COUNT_W-1:0]        gsize;

  logic signed [DOT_W-1:0]   dot_r;
  logic signed [ASUM_W-1:0]  asum_r;
  logic [COUNT_W-1:0]        count_r;
  logic [COUNT_W:0]          count_inc;

  logic [SCALE_W-1:0]        as_r;
  logic [SCALE_W-1:0]        ws_r;
  logic signed [ZERO_W-1:0]  wz_r;
  logic                      last_r;

  logic [PWS_W-1:0]          pws_r;
  logic signed [PWZ_W-1:0]   pwz_r;
  logic signed [SP_W-1:0]    sp_r;
  logic signed [ZP_W-1:0]    zp_r;
  logic signed [T1_W-1:0]    t1_r;
  logic signed [T2_W-1:0]    t2_r;
  logic signed [ACC_W-1:0]   term_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      clip_r;
  out_item_t                 out_r;

  logic signed [12:0]        prod_even;
  logic signed [12:0]        prod_odd;
  logic signed [13:0]        pair_dot;
  logic signed [8:0]         pair_sum;
  logic [PWS_W:0]            sp_sum;
  logic signed [PWZ_W-1:0]   zp_sum;
  logic signed [ACC_W:0]     row_sum;
  logic                      row_ovf;

  // effective group size: 0 acts as 1, large values clamp
  always_comb begin
    priority if (lg_r == '0) begin
      lg_eff = LOG2_W'(1);
    end else if (lg_r > LOG2_W'(MAX_GROUP_LOG2)) begin
      lg_eff = LOG2_W'(MAX_GROUP_LOG2);
    end else begin
      lg_eff = lg_r;
    end
  end

  assign gsize     = COUNT_W'(1) << lg_eff;
  assign count_inc = {1'b0, count_r} + (COUNT_W+1)'(2);

  assign prod_even = in_item.act_even * $signed({1'b0, in_item.weight_pair[3:0] & NIBBLE_MASK});
  assign prod_odd  = in_item.act_odd  * $signed({1'b0, in_item.weight_pair[7:4] & NIBBLE_MASK});
  assign pair_dot  = 14'(prod_even) + 14'(prod_odd);
  assign pair_sum  = 9'(in_item.act_even) + 9'(in_item.act_odd);

  assign stat.close_req = (count_inc >= {1'b0, gsize}) || in_item.last_of_row;
  assign stat.last      = last_r;

  assign sp_sum  = {1'b0, pws_r} + (PWS_W+1)'(HALF);
  assign zp_sum  = pwz_r + HALF;
  assign row_sum = {acc_r[ACC_W-1], acc_r} + {term_r[ACC_W-1], term_r};
  assign row_ovf = row_sum[ACC_W] != row_sum[ACC_W-1];

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= GROUP_LOG2_RST;
    end else if (cfg_we) begin
      lg_r <= cfg_data;
    end
  end

  // group and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r   <= '0;
      asum_r  <= '0;
      count_r <= '0;
      acc_r   <= '0;
      clip_r  <= 1'b0;
    end else begin
      if (cmd.acc_en) begin
        dot_r   <= dot_r + DOT_W'(pair_dot);
        asum_r  <= asum_r + ASUM_W'(pair_sum);
        count_r <= count_inc[COUNT_W-1:0];
      end
      if (cmd.row_en) begin
        dot_r   <= '0;
        asum_r  <= '0;
        count_r <= '0;
        if (row_ovf) begin
          acc_r  <= row_sum[ACC_W] ? ACC_MIN : ACC_MAX;
          clip_r <= 1'b1;
        end else begin
          acc_r  <= row_sum[ACC_W-1:0];
        end
      end
      if (cmd.emit_en) begin
        acc_r  <= '0;
        clip_r <= 1'b0;
      end
    end
  end

  // scale path payload
  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      as_r   <= in_item.act_scale;
      ws_r   <= in_item.weight_scale;
      wz_r   <= in_item.weight_zero;
      last_r <= in_item.last_of_row;
    end
    if (cmd.scale_en) begin
      pws_r <= as_r * ws_r;
      pwz_r <= $signed({1'b0, as_r}) * wz_r;
    end
    if (cmd.round_en) begin
      sp_r <= $signed({1'b0, sp_sum[PWS_W-1:SCALE_FRAC_BITS]});
      zp_r <= zp_sum[PWZ_W-1:SCALE_FRAC_BITS];
    end
    if (cmd.prod_en) begin
      t1_r <= dot_r * sp_r;
      t2_r <= asum_r * zp_r;
    end
    if (cmd.term_en) begin
      term_r <= ACC_W'(t1_r) + ACC_W'(t2_r);
    end
    if (cmd.emit_en) begin
      out_r.dot_value <= acc_r;
      out_r.saturated <= clip_r;
    end
  end

  assign out_item = out_r;

endmodule

// ===== src/qgdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// qgdp_ctrl
// Sequencer: takes items, steps the group close and loads the result.
// ----------------------------------------------------------------------------
module qgdp_ctrl import qgdp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_ROUND,
    S_PROD,
    S_TERM,
    S_ROW,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.acc_en   = accept;
    cmd.scale_en = (state_r == S_SCALE);
    cmd.round_en = (state_r == S_ROUND);
    cmd.prod_en  = (state_r == S_PROD);
    cmd.term_en  = (state_r == S_TERM);
    cmd.row_en   = (state_r == S_ROW);
    cmd.emit_en  = (state_r == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result wins over the one leaving in the same cycle
      priority if (cmd.emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && stat.close_req) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: state_r <= S_ROUND;
        S_ROUND: state_r <= S_PROD;
        S_PROD:  state_r <= S_TERM;
        S_TERM:  state_r <= S_ROW;
        S_ROW: begin
          state_r <= stat.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && stat.close_req |=> state_r == S_SCALE)
    else $error("group close did not start");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_en |=> out_valid && state_r == S_IDLE)
    else $error("loaded result not presented");

  a_mid_row_back: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_en && !stat.last |=> state_r == S_IDLE && !$rose(out_valid))
    else $error("result raised inside a row");
`endif

endmodule

// ===== src/q8_q4_group_dot_product.sv =====
// ----------------------------------------------------------------------------
// q8_q4_group_dot_product
// Group-quantized int8 x uint4 dot product with per-group zero point.
// ----------------------------------------------------------------------------
// Use:
//   in_*  : one item = two int8 activations, a byte of two 4-bit weights
//           (low nibble with act_even), and the group scales. Scales are only
//           used on the item that closes a group (group full or row end).
//   out_* : one item per row, on the input item marked last_of_row: the row
//           sum with 24 fraction bits and a flag if the accumulator clipped.
//   cfg_* : log2 of the group size, always ready; write only while idle.
// Flow: an item that does not close a group leaves in_ready high. A group
//   close holds in_ready low while the scale multiplies, the rounding, the
//   group products, the term add and the saturating row add each take one
//   registered step in the datapath. A row end adds the emit step to load
//   the output register, which holds while a result still waits; out_valid
//   rises once the output register is loaded.
// Stall: the result sits in an output register; the next row's items are
//   taken while it waits, and only the next row end holds until it leaves.
// Reset: group size back to 32 elements, all group and row sums cleared.
// ----------------------------------------------------------------------------
module q8_q4_group_dot_product import qgdp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LOG2_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  cmd_t  cmd;
  stat_t stat;

  // register write is a single flop load, never blocked
  assign cfg_ready = 1'b1;

  qgdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qgdp_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
